/* src/ipbh_pkg.sv */
`timescale 1ns / 1ps

package ipbh_pkg;

  // field widths
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned CAP_W   = 31;
  localparam int unsigned GROUP_W = 10;
  localparam int unsigned DIGIT_W = 3;
  localparam int unsigned CHAR_W  = 8;

  // characters of the address text
  localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  // a group holds at most three digits; the fourth is an error
  localparam logic [DIGIT_W-1:0] MAX_GROUP_DIGITS  = 3'd3;
  localparam logic [DIGIT_W-1:0] OVER_GROUP_DIGITS = 3'd4;

  localparam logic [KEY_W-1:0] KEY_ALL_ONES = {KEY_W{1'b1}};
  localparam logic [CAP_W-1:0] CAP_RESET    = 31'd1;

  // one remainder step per dividend bit
  localparam int unsigned MOD_CNT_W = $clog2(KEY_W);

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              last_char;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] address_key;
    logic [CAP_W-1:0] bucket_index;
    logic             parse_error;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] dividend;
    logic [CAP_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

/* src/ipbh_mod_unit.sv */
`timescale 1ns / 1ps

module ipbh_mod_unit import ipbh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mod_req_t         req_i,
  output mod_stat_t        stat_o,
  output logic [CAP_W-1:0] rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_W-1:0]     dvd_q, dvd_d;
  logic [CAP_W-1:0]     rem_q, rem_d;
  logic [CAP_W-1:0]     dsr_q, dsr_d;

  logic [CAP_W:0] trial;
  logic [CAP_W:0] diff;
  logic           fits;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, dvd_q[KEY_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = MOD_CNT_W'(KEY_W - 1);
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      dvd_d = {dvd_q[KEY_W-2:0], 1'b0};
      rem_d = fits ? diff[CAP_W-1:0] : trial[CAP_W-1:0];
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q;

endmodule

/* src/ip_address_bucket_hash_unit.sv */
`timescale 1ns / 1ps

// address bucket hash: takes a dotted address string one character a beat on
// the input channel (char_code plus last_char marking the string end) and
// returns one beat with the joined decimal key, groups zero-padded but the
// last, the key modulo the table capacity and a parse error flag.
// a colon or the last character ends the key; characters after a colon give
// no beat. the capacity register is written with cfg_we_i / cfg_wdata_i; the
// user must do so only while the block is idle, which the block itself does
// not enforce; zero acts as one. a digit or other character is handled in
// the idle state; a dot runs three times-ten steps and one add on the shared
// shift-add unit. after the character that ends a key, the last group runs up
// to three times-ten steps and one add, the remainder unit is started and runs
// 64 remainder steps, and the output register is loaded; only then is the
// next character taken. in_ready_o is low while an item is being worked on.
// the result sits in an output register: the next string is accepted while
// it waits; only a second result stalls, until the receiver takes the first.
// reset clears the string state, drops any held beat and sets capacity to one.
module ip_address_bucket_hash_unit import ipbh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_data_o,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_wdata_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_MODST = 3'd3;
  localparam logic [2:0] S_MODW  = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [CAP_W-1:0]   cap_q, cap_d;
  logic [KEY_W-1:0]   acc_q, acc_d;
  logic [GROUP_W-1:0] gv_q, gv_d;
  logic [DIGIT_W-1:0] gd_q, gd_d;
  logic               emitted_q, emitted_d;
  logic               err_q, err_d;
  logic               any_q, any_d;
  logic [KEY_W-1:0]   work_q, work_d;
  logic               ovf_q, ovf_d;
  logic [1:0]         steps_q, steps_d;
  logic               fin_q, fin_d;
  logic               last_q, last_d;
  logic               dot_q, dot_d;
  logic [KEY_W-1:0]   res_key_q, res_key_d;
  logic               res_err_q, res_err_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  mod_req_t           mod_req;
  mod_stat_t          mod_stat;
  logic [CAP_W-1:0]   mod_rem;

  logic               in_fire;
  logic [CHAR_W-1:0]  ch;
  logic               is_digit;
  logic [CHAR_W-1:0]  dig;
  logic [GROUP_W+3:0] gv_next;
  logic [KEY_W+3:0]   w10;
  logic [KEY_W:0]     sum;
  logic               go_app;
  logic               go_fin;
  logic [1:0]         app_steps;
  logic               key_bad;

  assign in_fire  = in_valid_i && in_ready_o;
  assign ch       = in_data_i.char_code;
  assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
  assign dig      = ch - CHAR_ZERO;
  assign gv_next  = {4'b0, gv_q} * 14'd10 + {10'b0, dig[3:0]};

  // shared shift-add unit: times ten, then add the group value
  assign w10 = ({4'b0, work_q} << 3) + ({4'b0, work_q} << 1);
  assign sum = {1'b0, work_q} + {{(KEY_W + 1 - GROUP_W){1'b0}}, gv_q};

  assign key_bad = err_q || !any_q;

  // remainder unit request
  assign mod_req.start    = (state_q == S_MODST);
  assign mod_req.dividend = key_bad ? KEY_ALL_ONES : acc_q;
  assign mod_req.divisor  = (cap_q == '0) ? CAP_RESET : cap_q;

  ipbh_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .stat_o (mod_stat),
    .rem_o  (mod_rem)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    cap_d       = cfg_we_i ? cfg_wdata_i : cap_q;
    acc_d       = acc_q;
    gv_d        = gv_q;
    gd_d        = gd_q;
    emitted_d   = emitted_q;
    err_d       = err_q;
    any_d       = any_q;
    work_d      = work_q;
    ovf_d       = ovf_q;
    steps_d     = steps_q;
    fin_d       = fin_q;
    last_d      = last_q;
    dot_d       = dot_q;
    res_key_d   = res_key_q;
    res_err_d   = res_err_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    go_app      = 1'b0;
    go_fin      = 1'b0;
    app_steps   = 2'd3;

    // output register drains independently
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (emitted_q) begin
            // skipping text after the colon
            if (in_data_i.last_char) begin
              acc_d     = '0;
              gv_d      = '0;
              gd_d      = '0;
              emitted_d = 1'b0;
              err_d     = 1'b0;
              any_d     = 1'b0;
            end
          end else if (ch == CHAR_COLON) begin
            go_fin = 1'b1;
            last_d = in_data_i.last_char;
          end else begin
            if (ch == CHAR_DOT) begin
              if (!err_q) begin
                go_app    = 1'b1;
                app_steps = 2'd3;
                dot_d     = 1'b1;
              end else begin
                gv_d = '0;
                gd_d = '0;
              end
            end else if (is_digit) begin
              any_d = 1'b1;
              if (gd_q >= MAX_GROUP_DIGITS) begin
                err_d = 1'b1;
                gd_d  = OVER_GROUP_DIGITS;
              end else begin
                gv_d = gv_next[GROUP_W-1:0];
                gd_d = gd_q + 1'b1;
              end
            end else begin
              err_d = 1'b1;
            end
            if (in_data_i.last_char) begin
              go_fin = 1'b1;
              last_d = 1'b1;
            end
          end

          // launch the append or the end of key
          if (go_app) begin
            work_d  = acc_q;
            ovf_d   = 1'b0;
            steps_d = app_steps;
            fin_d   = go_fin;
            state_d = S_MUL;
          end else if (go_fin) begin
            fin_d = 1'b1;
            if (!err_d && (gd_d != '0)) begin
              work_d  = acc_q;
              ovf_d   = 1'b0;
              steps_d = gd_d[1:0];
              dot_d   = 1'b0;
              state_d = S_MUL;
            end else begin
              state_d = S_MODST;
            end
          end
        end
      end
      S_MUL: begin
        work_d  = w10[KEY_W-1:0];
        ovf_d   = ovf_q || (w10[KEY_W+3:KEY_W] != 4'd0);
        steps_d = steps_q - 1'b1;
        if (steps_q == 2'd1) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        if (ovf_q || sum[KEY_W]) begin
          err_d = 1'b1;
        end else begin
          acc_d = sum[KEY_W-1:0];
        end
        if (dot_q) begin
          gv_d = '0;
          gd_d = '0;
        end
        dot_d   = 1'b0;
        state_d = fin_q ? S_MODST : S_IDLE;
      end
      S_MODST: begin
        res_key_d = mod_req.dividend;
        res_err_d = key_bad;
        state_d   = S_MODW;
      end
      S_MODW: begin
        if (mod_stat.done && (!out_valid_q || out_ready_i)) begin
          out_valid_d       = 1'b1;
          out_d.address_key  = res_key_q;
          out_d.bucket_index = mod_rem;
          out_d.parse_error  = res_err_q;
          fin_d              = 1'b0;
          if (last_q) begin
            acc_d     = '0;
            gv_d      = '0;
            gd_d      = '0;
            emitted_d = 1'b0;
            err_d     = 1'b0;
            any_d     = 1'b0;
          end else begin
            emitted_d = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      acc_q       <= '0;
      gv_q        <= '0;
      gd_q        <= '0;
      emitted_q   <= 1'b0;
      err_q       <= 1'b0;
      any_q       <= 1'b0;
      steps_q     <= '0;
      fin_q       <= 1'b0;
      last_q      <= 1'b0;
      dot_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      acc_q       <= acc_d;
      gv_q        <= gv_d;
      gd_q        <= gd_d;
      emitted_q   <= emitted_d;
      err_q       <= err_d;
      any_q       <= any_d;
      steps_q     <= steps_d;
      fin_q       <= fin_d;
      last_q      <= last_d;
      dot_q       <= dot_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    work_q    <= work_d;
    ovf_q     <= ovf_d;
    res_key_q <= res_key_d;
    res_err_q <= res_err_d;
    out_q     <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/ipbh_checker.sv */
`timescale 1ns / 1ps

module ipbh_checker import ipbh_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // a new result only follows a busy period of the sequencer
  a_rise_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without the remainder pass");

  // an error result carries the all-ones key
  a_err_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.parse_error |-> out_data_o.address_key == KEY_ALL_ONES)
    else $error("error result without all-ones key");

  // the remainder is always below the largest capacity
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.bucket_index != {CAP_W{1'b1}})
    else $error("bucket index out of range");

endmodule

bind ip_address_bucket_hash_unit ipbh_checker u_checker (.*);

/* sim/ip_address_bucket_hash_unit_tb.sv */
`timescale 1ns / 1ps

module ip_address_bucket_hash_unit_tb;
  import ipbh_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 9;
  localparam int IDLE_PCT       = 11;
  localparam int NOISE_PCT      = 10;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 235;
  localparam int DRAIN_CYCLES   = 150;
  localparam int MAX_REPORTS    = 10;
  localparam int TIMEOUT_CYCLES = 1000000;
  localparam int SCRIPT_LEN     = 25;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
    bit                typed;
    logic [KEY_W-1:0]  key;
    logic              perr;
  } script_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  // predictor state for the string in progress
  logic [KEY_W-1:0]   acc_key;
  logic [GROUP_W-1:0] grp_val;
  logic [DIGIT_W-1:0] grp_cnt;
  logic               key_done;
  logic               err_flag;
  logic               saw_digit;
  logic [CAP_W-1:0]   cap_reg;

  out_item_t pending_buckets [$];
  out_item_t want;
  int        mismatch_count = 0;
  bit        no_idle = 1'b0;

  // directed strings, typed results hold for the reset capacity of one
  script_row_t script_rows [SCRIPT_LEN] = '{
    '{"9",   1'b1, 1'b1, 64'd9,        1'b0},
    '{"0",   1'b0, 1'b0, '0,           1'b0},
    '{".",   1'b0, 1'b0, '0,           1'b0},
    '{"9",   1'b0, 1'b0, '0,           1'b0},
    '{"9",   1'b0, 1'b0, '0,           1'b0},
    '{":",   1'b0, 1'b1, 64'd99,       1'b0},
    '{8'hFF, 1'b1, 1'b0, '0,           1'b0},
    '{"1",   1'b0, 1'b0, '0,           1'b0},
    '{"2",   1'b0, 1'b0, '0,           1'b0},
    '{"3",   1'b0, 1'b0, '0,           1'b0},
    '{"4",   1'b1, 1'b1, KEY_ALL_ONES, 1'b1},
    '{8'h00, 1'b1, 1'b1, KEY_ALL_ONES, 1'b1},
    '{":",   1'b1, 1'b1, KEY_ALL_ONES, 1'b1},
    '{"7",   1'b0, 1'b0, '0,           1'b0},
    '{".",   1'b1, 1'b1, 64'd7,        1'b0},
    '{"5",   1'b0, 1'b0, '0,           1'b0},
    '{".",   1'b0, 1'b0, '0,           1'b0},
    '{":",   1'b1, 1'b1, 64'd5,        1'b0},
    '{"1",   1'b0, 1'b0, '0,           1'b0},
    '{".",   1'b0, 1'b0, '0,           1'b0},
    '{"2",   1'b0, 1'b0, '0,           1'b0},
    '{".",   1'b0, 1'b0, '0,           1'b0},
    '{"3",   1'b0, 1'b0, '0,           1'b0},
    '{".",   1'b0, 1'b0, '0,           1'b0},
    '{"4",   1'b1, 1'b0, '0,           1'b0}
  };

  ip_address_bucket_hash_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void clear_text();
    acc_key   = '0;
    grp_val   = '0;
    grp_cnt   = '0;
    key_done  = 1'b0;
    err_flag  = 1'b0;
    saw_digit = 1'b0;
  endfunction

  // key = key * mult + val, overflow of 64 bits marks the string bad
  function automatic void add_group(input logic [KEY_W-1:0] mult,
                                    input logic [KEY_W-1:0] val);
    if (acc_key > (KEY_ALL_ONES - val) / mult) err_flag = 1'b1;
    else acc_key = acc_key * mult + val;
  endfunction

  // final group goes in unpadded, then the bucket is taken
  function automatic out_item_t close_key();
    out_item_t        r;
    logic [KEY_W-1:0] mult;
    logic [KEY_W-1:0] divisor;
    mult = 64'd1;
    for (int i = 0; i < grp_cnt && i < MAX_GROUP_DIGITS; i++) mult = mult * 10;
    if (!err_flag && grp_cnt > 0) add_group(mult, KEY_W'(grp_val));
    if (err_flag || !saw_digit) begin
      r.address_key = KEY_ALL_ONES;
      r.parse_error = 1'b1;
    end else begin
      r.address_key = acc_key;
      r.parse_error = 1'b0;
    end
    divisor = (cap_reg == '0) ? 64'd1 : KEY_W'(cap_reg);
    r.bucket_index = CAP_W'(r.address_key % divisor);
    return r;
  endfunction

  // advances the predictor by one character, returns 1 when a beat is due
  function automatic bit predict_char(input logic [CHAR_W-1:0] c, input logic last,
                                      output out_item_t res);
    res = '0;
    if (key_done) begin
      if (last) clear_text();
      return 1'b0;
    end
    if (c == CHAR_COLON) begin
      res = close_key();
      if (last) clear_text();
      else key_done = 1'b1;
      return 1'b1;
    end
    if (c == CHAR_DOT) begin
      if (!err_flag) add_group(64'd1000, KEY_W'(grp_val));
      grp_val = '0;
      grp_cnt = '0;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      saw_digit = 1'b1;
      if (grp_cnt >= MAX_GROUP_DIGITS) begin
        err_flag = 1'b1;
        grp_cnt  = OVER_GROUP_DIGITS;
      end else begin
        grp_val = GROUP_W'(grp_val * 10 + GROUP_W'(c - CHAR_ZERO));
        grp_cnt = grp_cnt + 1'b1;
      end
    end else begin
      err_flag = 1'b1;
    end
    if (last) begin
      res = close_key();
      clear_text();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void flag_mismatch(input string what, input out_item_t exp_r,
                                        input out_item_t got_r);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch (%s): want key %h bucket %0d err %b, got key %h bucket %0d err %b",
               what, exp_r.address_key, exp_r.bucket_index, exp_r.parse_error,
               got_r.address_key, got_r.bucket_index, got_r.parse_error);
  endfunction

  // offers one character beat with random gaps, predicts on acceptance
  task automatic push_char(input in_item_t beat, input bit use_typed,
                           input out_item_t typed_res);
    out_item_t res;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_char(beat.char_code, beat.last_char, res))
      pending_buckets.insert(pending_buckets.size(), use_typed ? typed_res : res);
  endtask

  // lets every expected beat arrive and the remainder unit run dry
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_buckets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver back-pressure
  always @(posedge clk) out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_buckets.size() == 0) begin
        flag_mismatch("unexpected beat", '0, out_data);
      end else begin
        want = pending_buckets.pop_front();
        if (out_data.address_key !== want.address_key ||
            out_data.bucket_index !== want.bucket_index ||
            out_data.parse_error !== want.parse_error)
          flag_mismatch("field", want, out_data);
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("tb: failure");
    $finish;
  end

  initial begin
    in_item_t         text_q [$];
    in_item_t         beat;
    out_item_t        typed;
    logic [CAP_W-1:0] cap_plan [PHASES];
    int               phase_items;
    int               n_groups;
    int               n_digits;
    int               ending;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    cap_reg   = CAP_RESET;
    clear_text();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings at the reset capacity
    foreach (script_rows[k]) begin
      beat  = '{char_code: script_rows[k].ch, last_char: script_rows[k].last};
      typed = '{address_key: script_rows[k].key, bucket_index: '0,
                parse_error: script_rows[k].perr};
      push_char(beat, script_rows[k].typed, typed);
    end
    wait_idle();

    cap_plan[0] = '1;
    cap_plan[1] = '0;
    cap_plan[2] = CAP_W'($urandom_range(2, 32'h7FFF_FFFE));
    cap_plan[3] = CAP_W'(1);
    cap_plan[4] = CAP_W'($urandom_range(2, 1000));
    cap_plan[5] = CAP_W'($urandom_range(2, 32'h7FFF_FFFE));

    for (int p = 0; p < PHASES; p++) begin
      // capacity written while idle
      cfg_wdata <= cap_plan[p];
      cfg_we    <= 1'b1;
      @(posedge clk);
      cfg_we    <= 1'b0;
      cap_reg    = cap_plan[p];
      no_idle    = (p == 2);

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        text_q.delete();
        if ($urandom_range(0, 99) < NOISE_PCT) begin
          // raw bytes
          repeat ($urandom_range(1, 6))
            text_q.insert(text_q.size(), '{CHAR_W'($urandom), 1'b0});
        end else begin
          // dotted groups with the odd empty, overlong or stray character
          n_groups = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 4;
          for (int g = 0; g < n_groups; g++) begin
            if (g > 0) text_q.insert(text_q.size(), '{CHAR_DOT, 1'b0});
            case ($urandom_range(0, 19))
              0: n_digits = 0;
              1: n_digits = 4;
              default: n_digits = $urandom_range(1, 3);
            endcase
            repeat (n_digits)
              text_q.insert(text_q.size(),
                            '{CHAR_ZERO + CHAR_W'($urandom_range(0, 9)), 1'b0});
            if ($urandom_range(0, 39) == 0)
              text_q.insert(text_q.size(), '{CHAR_W'($urandom), 1'b0});
          end
          ending = $urandom_range(0, 9);
          if (ending == 0) begin
            text_q.insert(text_q.size(), '{CHAR_DOT, 1'b0});
          end else if (ending <= 4) begin
            // port text after the colon
            text_q.insert(text_q.size(), '{CHAR_COLON, 1'b0});
            repeat ($urandom_range(0, 5))
              text_q.insert(text_q.size(),
                            '{($urandom_range(0, 3) == 0) ? CHAR_W'($urandom) :
                              CHAR_ZERO + CHAR_W'($urandom_range(0, 9)), 1'b0});
          end
        end
        if (text_q.size() == 0) text_q.insert(0, '{CHAR_COLON, 1'b0});
        text_q[text_q.size() - 1].last_char = 1'b1;

        foreach (text_q[k]) begin
          push_char(text_q[k], 1'b0, '0);
          phase_items++;
        end
      end
      no_idle = 1'b0;
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
